/* rtl/bpg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpg_pkg
// Shared types, constants and microprogram ROM for the biphasic pulse generator.
// ----------------------------------------------------------------------------
package bpg_pkg;

    // Field widths
    localparam int FREQ_W  = 17;
    localparam int PULSE_W = 20;
    localparam int GAP_W   = 16;
    localparam int ELAP_W  = 22;
    localparam int QUO_W   = 20;
    localparam int IDX_W   = 3;
    localparam int CDAT_W  = 20;
    localparam int STEP_W  = 5;
    localparam int CNT_W   = 5;

    // Arithmetic constants
    localparam logic [QUO_W-1:0]   US_PER_SEC  = 20'd1000000;
    localparam logic [FREQ_W-1:0]  FREQ_MIN    = 17'd1;
    localparam logic [PULSE_W-1:0] PULSE_MIN   = 20'd10;
    localparam logic [ELAP_W-1:0]  TRIM_MARGIN = 22'd20;
    localparam logic [FREQ_W-1:0]  TRIM_GUARD  = 17'd40;
    localparam logic [ELAP_W-1:0]  WIN_EXTRA   = 22'd80;
    localparam logic [CNT_W-1:0]   DIV_STEPS   = 5'(QUO_W);

    // Reset values of the latched period state
    localparam logic [PULSE_W:0]  PG_RESET   = 21'd10;
    localparam logic [ELAP_W-1:0] SEQ_RESET  = 22'd20;
    localparam logic [ELAP_W-1:0] WLEN_RESET = 22'd100;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_RUN_ENABLE = 3'd0;
    localparam logic [IDX_W-1:0] REG_FREQ_HZ    = 3'd1;
    localparam logic [IDX_W-1:0] REG_PULSE_US   = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAP_US     = 3'd3;

    // Microprogram step addresses
    localparam logic [STEP_W-1:0] S_FETCH    = 5'd0;
    localparam logic [STEP_W-1:0] S_CHK_EN   = 5'd1;
    localparam logic [STEP_W-1:0] S_CHK_TICK = 5'd2;
    localparam logic [STEP_W-1:0] S_CHK_ST   = 5'd3;
    localparam logic [STEP_W-1:0] S_DIV_INIT = 5'd4;
    localparam logic [STEP_W-1:0] S_DIV_STEP = 5'd5;
    localparam logic [STEP_W-1:0] S_TRIM_CHK = 5'd6;
    localparam logic [STEP_W-1:0] S_TRIM_SUB = 5'd7;
    localparam logic [STEP_W-1:0] S_COMMIT   = 5'd8;
    localparam logic [STEP_W-1:0] S_SUM_PG   = 5'd9;
    localparam logic [STEP_W-1:0] S_SUM_SEQ  = 5'd10;
    localparam logic [STEP_W-1:0] S_LEN      = 5'd11;
    localparam logic [STEP_W-1:0] S_ADV      = 5'd12;
    localparam logic [STEP_W-1:0] S_DISABLE  = 5'd13;
    localparam logic [STEP_W-1:0] S_HOLD     = 5'd14;
    localparam logic [STEP_W-1:0] S_EMIT     = 5'd15;
    localparam logic [STEP_W-1:0] S_RET      = 5'd16;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_TRIM_CHK,
        OP_TRIM_SUB,
        OP_COMMIT,
        OP_SUM_PG,
        OP_SUM_SEQ,
        OP_LEN,
        OP_ADV,
        OP_DISABLE,
        OP_HOLD,
        OP_EMIT
    } t_op;

    // Branch taken when the condition is true, else fall through to step + 1
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_NOT_EN,
        C_NOT_TICK,
        C_NO_START,
        C_DIV_BUSY,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic tick;
        logic need_start;
        logic div_busy;
    } t_dp_stat;

    typedef struct packed {
        logic     in_valid;
        logic     out_free;
        logic     en;
        t_dp_stat dp;
    } t_seq_stat;

    typedef struct packed {
        logic               run_enable;
        logic [FREQ_W-1:0]  freq_hz;
        logic [PULSE_W-1:0] pulse_width_us;
        logic [GAP_W-1:0]   gap_us;
    } t_cfg;

    typedef struct packed {
        logic [PULSE_W-1:0] effective_pulse_us;
        logic               pulse_trimmed;
        logic [ELAP_W-1:0]  window_len_us;
        logic               window_start;
        logic               phase_b_level;
        logic               phase_a_level;
    } t_res;

    function automatic t_ctrl rom_word(input logic [STEP_W-1:0] step);
        t_ctrl w;
        unique case (step)
            S_FETCH:    w = '{op: OP_FETCH,    cond: C_NO_ITEM,  target: S_FETCH};
            S_CHK_EN:   w = '{op: OP_NOP,      cond: C_NOT_EN,   target: S_DISABLE};
            S_CHK_TICK: w = '{op: OP_NOP,      cond: C_NOT_TICK, target: S_HOLD};
            S_CHK_ST:   w = '{op: OP_NOP,      cond: C_NO_START, target: S_ADV};
            S_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEVER,    target: S_FETCH};
            S_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_BUSY, target: S_DIV_STEP};
            S_TRIM_CHK: w = '{op: OP_TRIM_CHK, cond: C_NEVER,    target: S_FETCH};
            S_TRIM_SUB: w = '{op: OP_TRIM_SUB, cond: C_NEVER,    target: S_FETCH};
            S_COMMIT:   w = '{op: OP_COMMIT,   cond: C_NEVER,    target: S_FETCH};
            S_SUM_PG:   w = '{op: OP_SUM_PG,   cond: C_NEVER,    target: S_FETCH};
            S_SUM_SEQ:  w = '{op: OP_SUM_SEQ,  cond: C_NEVER,    target: S_FETCH};
            S_LEN:      w = '{op: OP_LEN,      cond: C_NEVER,    target: S_FETCH};
            S_ADV:      w = '{op: OP_ADV,      cond: C_ALWAYS,   target: S_EMIT};
            S_DISABLE:  w = '{op: OP_DISABLE,  cond: C_ALWAYS,   target: S_EMIT};
            S_HOLD:     w = '{op: OP_HOLD,     cond: C_NEVER,    target: S_FETCH};
            S_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: S_EMIT};
            S_RET:      w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_FETCH};
            default:    w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_FETCH};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/bpg_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpg_seq
// Step counter and microprogram ROM with conditional branching.
// ----------------------------------------------------------------------------
module bpg_seq (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  bpg_pkg::t_seq_stat      i_stat,
    output bpg_pkg::t_ctrl          o_ctrl
);
    import bpg_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             ctrl;
    logic              take;

    assign ctrl = rom_word(r_step);

    always_comb begin
        unique case (ctrl.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_ITEM:  take = !i_stat.in_valid;
            C_NOT_EN:   take = !i_stat.en;
            C_NOT_TICK: take = !i_stat.dp.tick;
            C_NO_START: take = !i_stat.dp.need_start;
            C_DIV_BUSY: take = i_stat.dp.div_busy;
            C_OUT_BUSY: take = !i_stat.out_free;
            default:    take = 1'b1;
        endcase
    end

    always_comb begin
        n_step = take ? ctrl.target : r_step + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;

endmodule
`default_nettype wire

/* rtl/bpg_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpg_dp
// Datapath: restoring divider, pulse trim, period counter and phase levels.
// ----------------------------------------------------------------------------
module bpg_dp (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  bpg_pkg::t_ctrl          i_ctrl,
    input  bpg_pkg::t_cfg           i_cfg,
    input  wire                     i_in_valid,
    input  wire                     i_in_tick,
    output bpg_pkg::t_dp_stat       o_stat,
    output bpg_pkg::t_res           o_res
);
    import bpg_pkg::*;

    // Period state
    logic                r_running;
    logic [ELAP_W-1:0]   r_elapsed;
    logic [QUO_W-1:0]    r_period;
    logic [PULSE_W-1:0]  r_pulse;
    logic [GAP_W-1:0]    r_gap;
    logic                r_trim;
    logic [PULSE_W:0]    r_pg;
    logic [ELAP_W-1:0]   r_seq;
    logic [ELAP_W-1:0]   r_len;
    logic [ELAP_W-1:0]   r_wlen;
    logic                r_lvl_a;
    logic                r_lvl_b;

    // Per-transaction
    logic                r_tick;
    logic                r_res_a;
    logic                r_res_b;
    logic                r_res_ws;

    // Divider and trim scratch
    logic [FREQ_W-1:0]   r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic [FREQ_W-1:0]   r_divisor;
    logic [CNT_W-1:0]    r_cnt;
    logic [PULSE_W-1:0]  r_preq;
    logic [GAP_W-1:0]    r_greq;
    logic                r_need_trim;
    logic                r_gt;
    logic [QUO_W-1:0]    r_diff;

    logic [FREQ_W-1:0]   f_clamp;
    logic [PULSE_W-1:0]  p_clamp;
    logic [FREQ_W:0]     div_t;
    logic                div_ge;
    logic [FREQ_W:0]     div_sub;
    logic [ELAP_W-1:0]   trim_sum;
    logic [FREQ_W-1:0]   g_guard;
    logic [PULSE_W-1:0]  mp_raw;
    logic [PULSE_W-1:0]  mp;
    logic [ELAP_W-1:0]   pulse_x;
    logic [ELAP_W-1:0]   pg_x;
    logic [ELAP_W-1:0]   period_x;

    assign f_clamp = (i_cfg.freq_hz < FREQ_MIN) ? FREQ_MIN : i_cfg.freq_hz;
    assign p_clamp = (i_cfg.pulse_width_us < PULSE_MIN) ? PULSE_MIN : i_cfg.pulse_width_us;

    // One quotient bit per step
    assign div_t   = {r_rem, r_quo[QUO_W-1]};
    assign div_ge  = div_t >= {1'b0, r_divisor};
    assign div_sub = div_t - {1'b0, r_divisor};

    assign trim_sum = ELAP_W'({r_preq, 1'b0}) + ELAP_W'(r_greq) + TRIM_MARGIN;
    assign g_guard  = FREQ_W'(r_greq) + TRIM_GUARD;

    assign mp_raw = r_gt ? {1'b0, r_diff[QUO_W-1:1]} : PULSE_MIN;
    assign mp     = (mp_raw < PULSE_MIN) ? PULSE_MIN : mp_raw;

    assign pulse_x  = ELAP_W'(r_pulse);
    assign pg_x     = ELAP_W'(r_pg);
    assign period_x = ELAP_W'(r_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_elapsed <= '0;
            r_period  <= '0;
            r_pulse   <= PULSE_MIN;
            r_gap     <= '0;
            r_trim    <= 1'b0;
            r_pg      <= PG_RESET;
            r_seq     <= SEQ_RESET;
            r_len     <= '0;
            r_wlen    <= WLEN_RESET;
            r_lvl_a   <= 1'b0;
            r_lvl_b   <= 1'b0;
            r_tick    <= 1'b0;
            r_res_a   <= 1'b0;
            r_res_b   <= 1'b0;
            r_res_ws  <= 1'b0;
            r_cnt     <= '0;
        end else begin
            unique case (i_ctrl.op)
                OP_FETCH: begin
                    if (i_in_valid) begin
                        r_tick   <= i_in_tick;
                        r_res_ws <= 1'b0;
                    end
                end
                OP_DIV_INIT: begin
                    r_rem     <= '0;
                    r_quo     <= US_PER_SEC;
                    r_divisor <= f_clamp;
                    r_cnt     <= DIV_STEPS;
                    r_preq    <= p_clamp;
                    r_greq    <= i_cfg.gap_us;
                end
                OP_DIV_STEP: begin
                    r_rem <= div_ge ? div_sub[FREQ_W-1:0] : div_t[FREQ_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], div_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                OP_TRIM_CHK: begin
                    r_need_trim <= trim_sum >= ELAP_W'(r_quo);
                end
                OP_TRIM_SUB: begin
                    r_gt   <= r_quo > QUO_W'(g_guard);
                    r_diff <= r_quo - QUO_W'(g_guard);
                end
                OP_COMMIT: begin
                    r_period  <= r_quo;
                    r_pulse   <= r_need_trim ? mp : r_preq;
                    r_trim    <= r_need_trim;
                    r_gap     <= r_greq;
                    r_elapsed <= '0;
                    r_running <= 1'b1;
                    r_res_ws  <= 1'b1;
                end
                OP_SUM_PG: begin
                    r_pg <= (PULSE_W+1)'(r_pulse) + (PULSE_W+1)'(r_gap);
                end
                OP_SUM_SEQ: begin
                    r_seq <= pg_x + pulse_x;
                end
                OP_LEN: begin
                    r_len  <= (period_x > r_seq) ? period_x : r_seq;
                    r_wlen <= r_seq + WIN_EXTRA;
                end
                OP_ADV: begin
                    r_lvl_a   <= r_elapsed < pulse_x;
                    r_lvl_b   <= (r_elapsed >= pg_x) && (r_elapsed < r_seq);
                    r_res_a   <= r_elapsed < pulse_x;
                    r_res_b   <= (r_elapsed >= pg_x) && (r_elapsed < r_seq);
                    r_elapsed <= r_elapsed + ELAP_W'(1);
                end
                OP_DISABLE: begin
                    r_running <= 1'b0;
                    r_elapsed <= '0;
                    r_res_a   <= 1'b0;
                    r_res_b   <= 1'b0;
                    r_res_ws  <= 1'b0;
                end
                OP_HOLD: begin
                    // last elapsed tick levels, only while a period runs
                    r_res_a <= r_running && r_lvl_a;
                    r_res_b <= r_running && r_lvl_b;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.tick       = r_tick;
    assign o_stat.need_start = !r_running || (r_elapsed >= r_len);
    assign o_stat.div_busy   = r_cnt != CNT_W'(1);

    assign o_res.phase_a_level      = r_res_a;
    assign o_res.phase_b_level      = r_res_b;
    assign o_res.window_start       = r_res_ws;
    assign o_res.window_len_us      = r_wlen;
    assign o_res.pulse_trimmed      = r_trim;
    assign o_res.effective_pulse_us = r_pulse;

endmodule
`default_nettype wire

/* rtl/biphasic_pulse_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biphasic_pulse_generator
// Microsecond-tick driven biphasic pulse train with a microcoded sequencer.
// ----------------------------------------------------------------------------
// Each slave transaction carries one tick bit (1 = one microsecond elapsed)
// and yields exactly one master transaction with both phase levels, the
// window start flag and the latched period values. A transaction that opens
// a new period runs the restoring divider, computing 1000000/freq one
// quotient bit per microprogram step. Backpressure on the master side adds
// wait cycles at the emit step; the output register lets the next slave
// transaction be taken while the previous result is still waiting.
// Configuration is taken at any time and is sampled at the next period start
// (run_enable at each transaction).
// ----------------------------------------------------------------------------
module biphasic_pulse_generator (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // slave stream: [0] tick, [7:1] zero
    input  wire                            i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  wire  [7:0]                     i_s_axis_tdata,
    // master stream: [0] phase_a_level, [1] phase_b_level, [2] window_start,
    // [24:3] window_len_us, [25] pulse_trimmed, [45:26] effective_pulse_us,
    // [47:46] zero
    output logic                           o_m_axis_tvalid,
    input  wire                            i_m_axis_tready,
    output logic [47:0]                    o_m_axis_tdata,
    // configuration write channel
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [bpg_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire  [bpg_pkg::CDAT_W-1:0]     i_cfg_data
);
    import bpg_pkg::*;

    // Configuration registers
    logic               r_run_en;
    logic [FREQ_W-1:0]  r_freq;
    logic [PULSE_W-1:0] r_pulse_req;
    logic [GAP_W-1:0]   r_gap_req;

    // Output register
    logic               r_out_valid;
    t_res               r_out;

    t_ctrl              ctrl;
    t_cfg               cfg;
    t_dp_stat           dp_stat;
    t_seq_stat          seq_stat;
    t_res               res;
    logic               out_free;
    logic               emit;
    logic               cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_en    <= 1'b0;
            r_freq      <= 17'd100;
            r_pulse_req <= 20'd100;
            r_gap_req   <= 16'd20;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_RUN_ENABLE: r_run_en    <= i_cfg_data[0];
                REG_FREQ_HZ:    r_freq      <= i_cfg_data[FREQ_W-1:0];
                REG_PULSE_US:   r_pulse_req <= i_cfg_data[PULSE_W-1:0];
                REG_GAP_US:     r_gap_req   <= i_cfg_data[GAP_W-1:0];
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    assign cfg.run_enable     = r_run_en;
    assign cfg.freq_hz        = r_freq;
    assign cfg.pulse_width_us = r_pulse_req;
    assign cfg.gap_us         = r_gap_req;

    // Result slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign emit     = (ctrl.op == OP_EMIT) && out_free;

    assign seq_stat.in_valid = i_s_axis_tvalid;
    assign seq_stat.out_free = out_free;
    assign seq_stat.en       = r_run_en;
    assign seq_stat.dp       = dp_stat;

    bpg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (seq_stat),
        .o_ctrl  (ctrl)
    );

    bpg_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_cfg      (cfg),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_tick  (i_s_axis_tdata[0]),
        .o_stat     (dp_stat),
        .o_res      (res)
    );

    // Slave side is open only at the fetch step of the microprogram
    assign o_s_axis_tready = (ctrl.op == OP_FETCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out};

    // Phases are mutually exclusive
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.phase_a_level && r_out.phase_b_level))
        else $error("phase A and phase B high together");

    // A period always opens inside phase A
    a_start_in_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.window_start) |-> r_out.phase_a_level)
        else $error("window start outside phase A");

    // Trim never drops the pulse below its floor
    a_pulse_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.effective_pulse_us >= PULSE_MIN))
        else $error("effective pulse below floor");

    // One transaction in the microprogram at a time
    a_single_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second transaction taken back to back");

endmodule
`default_nettype wire

/* dv/tb_biphasic_pulse_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_biphasic_pulse_generator
// Self-checking bench for the biphasic pulse generator.
// ----------------------------------------------------------------------------
// Streams microsecond tick items into the block and checks every output
// transaction against a cycle-free model of the pulse train kept in the bench.
// Directed tests cover the idle state after reset, the pulse floor with a
// sequence longer than the period, the field extremes and unused register
// indexes. A random test follows with many short-period settings, random
// stalls on both streams and some phases without any idling.
// ----------------------------------------------------------------------------
module tb_biphasic_pulse_generator;
    import bpg_pkg::*;

    localparam int SETTLE_CYCLES = 40;   // covers a full period start in the microprogram
    localparam longint unsigned MASK20 = 64'hF_FFFF;
    localparam longint unsigned MASK22 = 64'h3F_FFFF;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_valid;
    logic [7:0]          s_data;
    wire                 s_ready;
    wire                 m_valid;
    logic                m_ready;
    wire  [47:0]         m_data;
    logic                c_valid;
    wire                 c_ready;
    logic [IDX_W-1:0]    c_index;
    logic [CDAT_W-1:0]   c_data;

    // Set during phases that run the streams back to back
    bit                  quiet_mode;
    int                  fail_count;

    // Outputs still owed by the block, oldest first
    t_res                pending_levels[$];

    // Register shadow
    logic                sh_run;
    logic [FREQ_W-1:0]   sh_freq;
    logic [PULSE_W-1:0]  sh_pulse;
    logic [GAP_W-1:0]    sh_gap;

    // Pulse train state
    longint unsigned     pg_elapsed, pg_period, pg_pulse, pg_gap;
    logic                pg_trim, pg_running;

    always #1 i_clk = ~i_clk;

    biphasic_pulse_generator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),     // [0] tick, [7:1] zero
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),     // [0] phase_a, [1] phase_b, [2] window_start,
                                       // [24:3] window_len, [25] trimmed,
                                       // [45:26] effective_pulse, [47:46] zero
        .i_cfg_valid     (c_valid),
        .o_cfg_ready     (c_ready),
        .i_cfg_index     (c_index),
        .i_cfg_data      (c_data)
    );

    // ------------------------------------------------------------------------
    // Pulse train model
    // ------------------------------------------------------------------------
    function automatic void reset_pulse_model();
        sh_run     = 1'b0;
        sh_freq    = 17'd100;
        sh_pulse   = 20'd100;
        sh_gap     = 16'd20;
        pg_elapsed = 0;
        pg_period  = 0;
        pg_pulse   = 10;
        pg_gap     = 0;
        pg_trim    = 1'b0;
        pg_running = 1'b0;
    endfunction

    // Latch the settings for a new period: clamp, divide, trim.
    function automatic void open_period();
        longint unsigned f, p, per, g, mp;
        f   = (sh_freq < 1) ? 1 : sh_freq;
        p   = (sh_pulse < 10) ? 10 : sh_pulse;
        per = 1000000 / f;
        g   = sh_gap;
        pg_trim = 1'b0;
        if (2 * p + g + 20 >= per) begin
            // shrink to fit; too short a period falls back to the 10 us floor
            mp = (per > g + 40) ? (per - (g + 40)) / 2 : 10;
            if (mp < 10) mp = 10;
            p = mp;
            pg_trim = 1'b1;
        end
        pg_period  = per & MASK20;
        pg_pulse   = p & MASK20;
        pg_gap     = g;
        pg_elapsed = 0;
        pg_running = 1'b1;
    endfunction

    function automatic void phase_levels(input longint unsigned pos,
                                         output logic a, output logic b);
        a = pos < pg_pulse;
        b = (pos >= pg_pulse + pg_gap) && (pos < 2 * pg_pulse + pg_gap);
    endfunction

    // Advance the model by one item and return the output it produces.
    function automatic t_res next_pulse_levels(input logic tick);
        t_res            r;
        logic            a, b, ws;
        longint unsigned seq, span;
        a  = 1'b0;
        b  = 1'b0;
        ws = 1'b0;
        if (!sh_run) begin
            pg_running = 1'b0;
            pg_elapsed = 0;
        end else if (tick) begin
            if (!pg_running) begin
                open_period();
                ws = 1'b1;
            end else begin
                // a sequence longer than the period stretches it
                seq  = 2 * pg_pulse + pg_gap;
                span = (pg_period > seq) ? pg_period : seq;
                if (pg_elapsed >= span) begin
                    open_period();
                    ws = 1'b1;
                end
            end
            phase_levels(pg_elapsed, a, b);
            pg_elapsed = (pg_elapsed + 1) & MASK22;
        end else if (pg_running && pg_elapsed > 0) begin
            // no time passes: repeat the levels of the last tick
            phase_levels(pg_elapsed - 1, a, b);
        end
        r.phase_a_level      = a;
        r.phase_b_level      = b;
        r.window_start       = ws;
        r.window_len_us      = ELAP_W'((2 * pg_pulse + pg_gap + 80) & MASK22);
        r.pulse_trimmed      = pg_trim;
        r.effective_pulse_us = PULSE_W'(pg_pulse & MASK20);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stream and register drivers (all driving at the falling edge)
    // ------------------------------------------------------------------------
    // Leaves tvalid high on return so a back-to-back item needs no toggle.
    task automatic send_tick(input logic tick);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data  = {7'd0, tick};
        do @(posedge i_clk); while (!s_ready);
        pending_levels.push_back(next_pulse_levels(tick));
        @(negedge i_clk);
    endtask

    // Stop sending, let every owed output arrive, then let the block settle.
    task automatic wait_for_outputs();
        s_valid = 1'b0;
        while (pending_levels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
        c_valid = 1'b1;
        c_index = idx;
        c_data  = data;
        do @(posedge i_clk); while (!c_ready);
        case (idx)
            REG_RUN_ENABLE: sh_run   = data[0];
            REG_FREQ_HZ:    sh_freq  = data[FREQ_W-1:0];
            REG_PULSE_US:   sh_pulse = data[PULSE_W-1:0];
            REG_GAP_US:     sh_gap   = data[GAP_W-1:0];
            default: ;      // unused index, no effect
        endcase
        @(negedge i_clk);
        c_valid = 1'b0;
    endtask

    // Master side: random stall before each transaction
    initial begin
        int stall;
        m_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = quiet_mode ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready = 1'b1;
            do @(posedge i_clk); while (!(m_valid && i_rst_n));
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Output check
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && m_valid && m_ready) begin
            got = t_res'(m_data[45:0]);
            if (pending_levels.size() == 0) begin
                $error("output transaction with nothing owed: 0x%h", m_data);
                fail_count++;
            end else begin
                want = pending_levels.pop_front();
                check_field("phase_a_level", want.phase_a_level, got.phase_a_level);
                check_field("phase_b_level", want.phase_b_level, got.phase_b_level);
                check_field("window_start", want.window_start, got.window_start);
                check_field("window_len_us", want.window_len_us, got.window_len_us);
                check_field("pulse_trimmed", want.pulse_trimmed, got.pulse_trimmed);
                check_field("effective_pulse_us", want.effective_pulse_us,
                            got.effective_pulse_us);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Disabled after reset: levels low, latched fields at reset values.
    task automatic test_idle_after_reset();
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // 100 kHz gives a 10 us period; pulse 0 clamps to 10 and trims to the
    // floor, so phase B runs past the end of the period.
    task automatic test_floor_trim_long_sequence();
        wait_for_outputs();
        write_reg(REG_FREQ_HZ, 20'd100000);
        write_reg(REG_PULSE_US, 20'd0);
        write_reg(REG_GAP_US, 20'd0);
        write_reg(REG_RUN_ENABLE, 20'd1);
        send_tick(1'b0);            // enabled but no time yet
        repeat (5) send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Each setting is applied while disabled, then a fresh period is opened.
    task automatic test_field_extremes();
        logic [CDAT_W-1:0] freqs[4];
        logic [CDAT_W-1:0] pulses[4];
        logic [CDAT_W-1:0] gaps[4];
        freqs  = '{20'd0,       20'hFFFFF, 20'd1000, 20'd22222};
        pulses = '{20'hFFFFF,   20'd9,     20'd600,  20'd100};
        gaps   = '{20'h0FFFF,   20'd0,     20'd100,  20'd0};
        for (int i = 0; i < 4; i++) begin
            wait_for_outputs();
            write_reg(REG_RUN_ENABLE, 20'd0);
            send_tick(1'b1);
            wait_for_outputs();
            // freq 0 -> 1 Hz; masked freq; normal trim; trim below the floor
            write_reg(REG_FREQ_HZ, freqs[i]);
            write_reg(REG_PULSE_US, pulses[i]);
            write_reg(REG_GAP_US, gaps[i]);
            write_reg(REG_RUN_ENABLE, 20'd1);
            send_tick(1'b1);
            send_tick(1'b0);
        end
    endtask

    // Writes past the register list must change nothing.
    task automatic test_unused_indexes();
        wait_for_outputs();
        for (int idx = REG_GAP_US + 1; idx < 2 ** IDX_W; idx++)
            write_reg(IDX_W'(idx), '0);
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    task automatic pick_random_setup();
        logic [CDAT_W-1:0] freq, pulse, gap;
        case ($urandom_range(0, 9))
            0:       freq = 20'd0;
            1:       freq = 20'd100000;
            2:       freq = CDAT_W'($urandom);     // upper bits masked off
            default: freq = CDAT_W'($urandom_range(4000, 100000));
        endcase
        case ($urandom_range(0, 9))
            0:       pulse = 20'hFFFFF;
            1:       pulse = CDAT_W'($urandom);
            2:       pulse = 20'd0;
            default: pulse = CDAT_W'($urandom_range(0, 60));
        endcase
        case ($urandom_range(0, 9))
            0:       gap = 20'h0FFFF;
            1:       gap = CDAT_W'($urandom_range(0, 65535));
            default: gap = CDAT_W'($urandom_range(0, 40));
        endcase
        // unwritten registers keep their value into the next period
        if ($urandom_range(0, 3) != 0) write_reg(REG_FREQ_HZ, freq);
        if ($urandom_range(0, 3) != 0) write_reg(REG_PULSE_US, pulse);
        if ($urandom_range(0, 3) != 0) write_reg(REG_GAP_US, gap);
        write_reg(REG_RUN_ENABLE, CDAT_W'($urandom_range(0, 7) != 0));
    endtask

    // Phases of random ticks; settings change between phases, often in the
    // middle of a running period, so they land at the next period start.
    task automatic test_random_trains();
        for (int phase = 0; phase < 16; phase++) begin
            wait_for_outputs();
            quiet_mode = (phase % 4 == 3);
            pick_random_setup();
            repeat (100) send_tick($urandom_range(0, 9) < 8);
        end
        wait_for_outputs();
        quiet_mode = 1'b0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        c_valid    = 1'b0;
        c_index    = '0;
        c_data     = '0;
        quiet_mode = 1'b0;
        fail_count = 0;
        reset_pulse_model();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_after_reset();
        test_floor_trim_long_sequence();
        test_field_extremes();
        test_unused_indexes();
        test_random_trains();

        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
